@@ sv/stp_pkg.sv @@
// Package for the scrolling trace plotter: geometry constants, register
// indexes, draw codes, controller states and the divider status struct.
// Used by the top module, the divider and the testbench.
package stp_pkg;

  // Trace geometry.
  localparam int unsigned TRACE_COLUMNS = 128;
  localparam int unsigned CLEAR_OFFSET  = 10;
  localparam int unsigned COL_W         = $clog2(TRACE_COLUMNS);
  localparam int unsigned ERASE_RESET   = CLEAR_OFFSET % TRACE_COLUMNS;

  // Field widths.
  localparam int unsigned DATA_W = 16;
  localparam int unsigned X_W    = 7;
  localparam int unsigned Y_W    = 6;

  // Row mapping: row = ROW_BASE - floor(scaled * ROW_SPAN / 2**SCALE_BITS).
  localparam int unsigned ROW_BASE     = 55;
  localparam int unsigned ROW_SPAN     = 35;
  localparam int unsigned ROW_TOP      = 20;
  localparam int unsigned ERASE_TOP    = 19;
  localparam int unsigned ERASE_BOTTOM = 56;
  localparam int unsigned SCALE_BITS   = 10;
  localparam int unsigned Q_W          = SCALE_BITS + 1;
  localparam int unsigned DIV_CNT_W    = $clog2(Q_W);
  localparam int unsigned PROD_W       = Q_W + 6;
  localparam int unsigned DROP_W       = PROD_W - SCALE_BITS;

  // Configuration registers.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACE_MAX = 2'd1;
  localparam logic signed [DATA_W-1:0] TRACE_MIN_RESET = 16'sd0;
  localparam logic signed [DATA_W-1:0] TRACE_MAX_RESET = 16'sd8192;

  // Draw command codes.
  localparam logic DRAW_PIXEL = 1'b0;
  localparam logic DRAW_LINE  = 1'b1;
  localparam logic INK_OFF    = 1'b0;
  localparam logic INK_ON     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_DIV,
    ST_ROW,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_CMD1,
    ST_CMD2,
    ST_CMD3
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ sv/scrolling_trace_plotter_top.sv @@
// Strip-chart trace renderer: one absorbance sample in, three draw transfers out.
// Depends on stp_pkg, stp_div and stp_ram.
//
// Each sample is accepted, clamped, divided in the bit-serial divider (one
// quotient bit per cycle), mapped to a row, then the two old rows are read from
// the row ring RAM through its single read port (RD0, RD1, RD2), and the three
// commands are handed out. A span (trace_max - trace_min) that is not positive
// skips the divider and the row mapping. A command waits while the output
// register is still full. One sample is processed at a time; the next sample is
// taken while the final command may still wait in the output register. The row
// ring needs no clearing pass: per-entry valid bits make unwritten rows read zero.
module scrolling_trace_plotter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [stp_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [stp_pkg::DATA_W-1:0] absorbance_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          draw_kind_o,
  output logic [stp_pkg::X_W-1:0]       x_start_o,
  output logic [stp_pkg::Y_W-1:0]       y_start_o,
  output logic [stp_pkg::X_W-1:0]       x_end_o,
  output logic [stp_pkg::Y_W-1:0]       y_end_o,
  output logic                          ink_on_o,
  output logic                          last_command_o
);
  import stp_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(TRACE_COLUMNS - 1);

  state_e state_q, state_d;

  logic signed [DATA_W-1:0] min_q, max_q;
  logic signed [DATA_W-1:0] sample_q;
  logic [COL_W-1:0] plot_col_q, erase_col_q;
  logic [Y_W-1:0]   prev_row_q, row_q, row_d;
  logic [Y_W-1:0]   rd0_q, rd1_q;
  logic [TRACE_COLUMNS-1:0] row_vld_q;
  logic             rd_vld_q;

  // Controller outputs.
  logic             in_ready, div_start, ram_re, load_out, commit, row_load;
  logic             rd0_load, rd1_load;
  logic [COL_W-1:0] ram_raddr;
  logic             cmd_kind, cmd_ink, cmd_last;
  logic [X_W-1:0]   cmd_xs, cmd_xe;
  logic [Y_W-1:0]   cmd_ys, cmd_ye;

  // Output register.
  logic             out_valid_q;
  logic             out_kind_q, out_ink_q, out_last_q;
  logic [X_W-1:0]   out_xs_q, out_xe_q;
  logic [Y_W-1:0]   out_ys_q, out_ye_q;
  logic             out_free;

  // Clamp and span.
  logic signed [DATA_W-1:0] clamp_a;
  logic signed [DATA_W:0]   diff, span;
  logic                     span_pos;

  // Divider and row mapping.
  logic [Q_W-1:0]    quo;
  div_stat_t         div_stat;
  logic [PROD_W-1:0] prod;
  logic [DROP_W-1:0] drop;
  logic [DROP_W-1:0] row_cand;
  logic [Y_W-1:0]    ram_rdata;
  logic [Y_W-1:0]    rd_word;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    clamp_a = sample_q;
    if (clamp_a < min_q) begin
      clamp_a = min_q;
    end
    if (clamp_a > max_q) begin
      clamp_a = max_q;
    end
    diff     = {clamp_a[DATA_W-1], clamp_a} - {min_q[DATA_W-1], min_q};
    span     = {max_q[DATA_W-1], max_q} - {min_q[DATA_W-1], min_q};
    span_pos = !span[DATA_W] && (span != '0);
  end

  stp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff[DATA_W-1:0]),
    .divisor_i  (span[DATA_W-1:0]),
    .quo_o      (quo),
    .stat_o     (div_stat)
  );

  always_comb begin
    prod     = PROD_W'(quo) * PROD_W'(ROW_SPAN);
    drop     = prod[PROD_W-1:SCALE_BITS];
    row_cand = DROP_W'(ROW_BASE) - drop;
    row_d    = prev_row_q;
    if ((drop <= DROP_W'(ROW_BASE)) && (row_cand >= DROP_W'(ROW_TOP))) begin
      row_d = Y_W'(row_cand);
    end
  end

  stp_ram #(
    .WIDTH (Y_W),
    .DEPTH (TRACE_COLUMNS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (plot_col_q),
    .wdata_i (row_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_word = rd_vld_q ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    div_start = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = erase_col_q;
    load_out  = 1'b0;
    commit    = 1'b0;
    row_load  = 1'b0;
    rd0_load  = 1'b0;
    rd1_load  = 1'b0;
    cmd_kind  = DRAW_LINE;
    cmd_ink   = INK_OFF;
    cmd_last  = 1'b0;
    cmd_xs    = X_W'(erase_col_q);
    cmd_xe    = X_W'(erase_col_q);
    cmd_ys    = Y_W'(ERASE_TOP);
    cmd_ye    = Y_W'(ERASE_BOTTOM);
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (span_pos) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_RD0;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        row_load = 1'b1;
        state_d  = ST_RD0;
      end
      ST_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = (erase_col_q == '0) ? '0 : erase_col_q - 1'b1;
        state_d   = ST_RD1;
      end
      ST_RD1: begin
        rd0_load = 1'b1;
        ram_re   = 1'b1;
        state_d  = ST_RD2;
      end
      ST_RD2: begin
        rd1_load = 1'b1;
        state_d  = ST_CMD1;
      end
      ST_CMD1: begin
        if (erase_col_q == '0) begin
          cmd_kind = DRAW_PIXEL;
          cmd_xs   = '0;
          cmd_xe   = '0;
          cmd_ys   = rd0_q;
          cmd_ye   = rd0_q;
        end else begin
          cmd_xs = X_W'(erase_col_q - 1'b1);
          cmd_ys = rd0_q;
          cmd_ye = rd1_q;
        end
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_CMD2;
        end
      end
      ST_CMD2: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_CMD3;
        end
      end
      ST_CMD3: begin
        cmd_ink  = INK_ON;
        cmd_last = 1'b1;
        cmd_xe   = X_W'(plot_col_q);
        cmd_ye   = row_q;
        if (plot_col_q == '0) begin
          cmd_kind = DRAW_PIXEL;
          cmd_xs   = '0;
          cmd_ys   = row_q;
        end else begin
          cmd_xs = X_W'(plot_col_q - 1'b1);
          cmd_ys = prev_row_q;
        end
        if (out_free) begin
          load_out = 1'b1;
          commit   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = in_ready;

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= TRACE_MIN_RESET;
      max_q       <= TRACE_MAX_RESET;
      plot_col_q  <= '0;
      erase_col_q <= COL_W'(ERASE_RESET);
      prev_row_q  <= '0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TRACE_MIN: min_q <= cfg_data_i;
          CFG_TRACE_MAX: max_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (commit) begin
        prev_row_q            <= row_q;
        row_vld_q[plot_col_q] <= 1'b1;
        plot_col_q  <= (plot_col_q == COL_LAST) ? '0 : plot_col_q + 1'b1;
        erase_col_q <= (erase_col_q == COL_LAST) ? '0 : erase_col_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      sample_q <= absorbance_i;
    end
    if (state_q == ST_CLAMP) begin
      row_q <= prev_row_q;
    end else if (row_load) begin
      row_q <= row_d;
    end
    if (ram_re) begin
      rd_vld_q <= row_vld_q[ram_raddr];
    end
    if (rd0_load) begin
      rd0_q <= rd_word;
    end
    if (rd1_load) begin
      rd1_q <= rd_word;
    end
    if (load_out) begin
      out_kind_q <= cmd_kind;
      out_xs_q   <= cmd_xs;
      out_ys_q   <= cmd_ys;
      out_xe_q   <= cmd_xe;
      out_ye_q   <= cmd_ye;
      out_ink_q  <= cmd_ink;
      out_last_q <= cmd_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign draw_kind_o    = out_kind_q;
  assign x_start_o      = out_xs_q;
  assign y_start_o      = out_ys_q;
  assign x_end_o        = out_xe_q;
  assign y_end_o        = out_ye_q;
  assign ink_on_o       = out_ink_q;
  assign last_command_o = out_last_q;

  a_last_is_ink : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_command_o == ink_on_o))
    else $error("only the final command of a sample draws with ink");

  a_pixel_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (draw_kind_o == DRAW_PIXEL)) |->
      ((x_start_o == '0) && (x_end_o == '0) && (y_start_o == y_end_o)))
    else $error("pixel command is not a single point at column zero");

  a_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_stat.busy)
    else $error("divider busy while waiting for a sample");

endmodule

@@ sv/stp_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module stp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/stp_div.sv @@
// Bit-serial restoring divider: floor(d * 2**SCALE_BITS / span), one
// quotient bit per cycle. Depends on stp_pkg.
module stp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [stp_pkg::DATA_W-1:0] dividend_i,
  input  logic [stp_pkg::DATA_W-1:0] divisor_i,
  output logic [stp_pkg::Q_W-1:0]    quo_o,
  output stp_pkg::div_stat_t          stat_o
);
  import stp_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(Q_W - 1);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    dsr_q, dsr_d;
  logic [Q_W-1:0]       num_q, num_d;
  logic [Q_W-1:0]       quo_q, quo_d;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic                 fits;
  logic                 done;

  assign done = busy_q && (cnt_q == LAST_STEP);

  // The dividend is d shifted left by SCALE_BITS. Its bits above the
  // quotient width are d >> 1, which is already below the divisor when
  // d <= span, so the partial remainder starts there.
  always_comb begin
    trial = {rem_q, num_q[Q_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = !diff[DATA_W];
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i >> 1;
      dsr_d  = divisor_i;
      num_d  = {dividend_i[0], {(Q_W-1){1'b0}}};
    end else if (busy_q) begin
      rem_d = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_d = {quo_q[Q_W-2:0], fits};
      num_d = {num_q[Q_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (done) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !busy_q)
    else $error("divider still busy after its last step");

endmodule

@@ tb/scrolling_trace_plotter_top_tb.sv @@
// Self-checking testbench for scrolling_trace_plotter_top: directed table, then random phases
// with idle and stall patterns, checked against an in-bench row and draw-command predictor.
// Depends on stp_pkg and the RTL of the block.
module scrolling_trace_plotter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 19;
  localparam int N_DIRECTED   = 29;
  localparam longint SCALE_FULL = longint'(1) << SCALE_BITS;

  // Indexes beyond the two defined registers; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic STEP_SAMPLE = 1'b0;
  localparam logic STEP_CFG    = 1'b1;

  typedef struct packed {
    logic           kind;
    logic [X_W-1:0] xs;
    logic [Y_W-1:0] ys;
    logic [X_W-1:0] xe;
    logic [Y_W-1:0] ye;
    logic           ink;
    logic           last;
  } draw_cmd_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DATA_W-1:0]    value;
    logic                 row_known;
    logic [Y_W-1:0]       row;
  } plot_step_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [DATA_W-1:0]        cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] absorbance_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     draw_kind_o;
  logic [X_W-1:0]           x_start_o;
  logic [Y_W-1:0]           y_start_o;
  logic [X_W-1:0]           x_end_o;
  logic [Y_W-1:0]           y_end_o;
  logic                     ink_on_o;
  logic                     last_command_o;

  scrolling_trace_plotter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .absorbance_i   (absorbance_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .draw_kind_o    (draw_kind_o),
    .x_start_o      (x_start_o),
    .y_start_o      (y_start_o),
    .x_end_o        (x_end_o),
    .y_end_o        (y_end_o),
    .ink_on_o       (ink_on_o),
    .last_command_o (last_command_o)
  );

  // Predictor state, mirroring the block.
  logic [Y_W-1:0]           row_ring [TRACE_COLUMNS];
  logic [COL_W-1:0]         plot_col;
  logic [COL_W-1:0]         erase_col;
  logic [Y_W-1:0]           last_row;
  logic signed [DATA_W-1:0] trace_min;
  logic signed [DATA_W-1:0] trace_max;

  draw_cmd_t pending_draws[$];
  int        errors = 0;
  int        cycle_count = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  int        hold_off_req = 0;

  plot_step_t directed [N_DIRECTED] = '{
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h0000, 1'b1, 6'd55},  // bottom of the default span
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h7FFF, 1'b1, 6'd20},  // clamped to the maximum
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h8000, 1'b1, 6'd55},  // clamped to the minimum
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h1000, 1'b1, 6'd38},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h2000, 1'b1, 6'd20},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h1FFF, 1'b1, 6'd21},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'hFFFF, 1'b1, 6'd55},
    '{STEP_CFG,    CFG_SPARE_2,   16'hFFFF, 1'b0, 6'd0},
    '{STEP_CFG,    CFG_SPARE_3,   16'h0000, 1'b0, 6'd0},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h1000, 1'b1, 6'd38},  // spare writes changed nothing
    '{STEP_CFG,    CFG_TRACE_MIN, 16'h8000, 1'b0, 6'd0},
    '{STEP_CFG,    CFG_TRACE_MAX, 16'h7FFF, 1'b0, 6'd0},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h8000, 1'b1, 6'd55},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h7FFF, 1'b1, 6'd20},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h0000, 1'b1, 6'd38},
    '{STEP_CFG,    CFG_TRACE_MIN, 16'h2000, 1'b0, 6'd0},
    '{STEP_CFG,    CFG_TRACE_MAX, 16'h2000, 1'b0, 6'd0},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h0000, 1'b1, 6'd38},  // empty span keeps the last row
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h7FFF, 1'b1, 6'd38},
    '{STEP_CFG,    CFG_TRACE_MIN, 16'h7FFF, 1'b0, 6'd0},
    '{STEP_CFG,    CFG_TRACE_MAX, 16'h8000, 1'b0, 6'd0},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h1234, 1'b1, 6'd38},  // inverted span keeps the last row
    '{STEP_CFG,    CFG_TRACE_MIN, 16'hF000, 1'b0, 6'd0},
    '{STEP_CFG,    CFG_TRACE_MAX, 16'h1000, 1'b0, 6'd0},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h0800, 1'b0, 6'd0},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'hF000, 1'b1, 6'd55},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'hFFFF, 1'b0, 6'd0},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'h5555, 1'b0, 6'd0},
    '{STEP_SAMPLE, CFG_TRACE_MIN, 16'hAAAA, 1'b0, 6'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run timed out after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Pixel row for a sample under the current clamp settings.
  function automatic logic [Y_W-1:0] trace_row(input logic signed [DATA_W-1:0] sample);
    longint         s;
    longint         lo;
    longint         hi;
    longint         span;
    longint         scaled;
    longint         drop;
    logic [Y_W-1:0] row;
    row  = last_row;
    s    = sample;
    lo   = trace_min;
    hi   = trace_max;
    span = hi - lo;
    if (s < lo) s = lo;
    if (s > hi) s = hi;
    if (span > 0) begin
      scaled = ((s - lo) * SCALE_FULL) / span;
      drop   = (scaled * longint'(ROW_SPAN)) / SCALE_FULL;
      if (drop <= longint'(ROW_BASE) && longint'(ROW_BASE) - drop >= longint'(ROW_TOP)) begin
        row = Y_W'(longint'(ROW_BASE) - drop);
      end
    end
    return row;
  endfunction

  // Queues the three draw commands of one sample and advances the columns.
  task automatic push_draw_commands(input logic [DATA_W-1:0] sample, input logic row_known,
                                    input logic [Y_W-1:0] known_row);
    logic [Y_W-1:0]   row;
    logic [COL_W-1:0] c;
    logic [COL_W-1:0] p;
    row = row_known ? known_row : trace_row(sample);
    c   = erase_col;
    p   = plot_col;
    if (c == '0) begin
      pending_draws.push_back('{DRAW_PIXEL, '0, row_ring[0], '0, row_ring[0], INK_OFF, 1'b0});
    end else begin
      pending_draws.push_back('{DRAW_LINE, c - 1'b1, row_ring[c - 1'b1], c, row_ring[c],
                                INK_OFF, 1'b0});
    end
    pending_draws.push_back('{DRAW_LINE, c, Y_W'(ERASE_TOP), c, Y_W'(ERASE_BOTTOM),
                              INK_OFF, 1'b0});
    if (p == '0) begin
      pending_draws.push_back('{DRAW_PIXEL, '0, row, '0, row, INK_ON, 1'b1});
    end else begin
      pending_draws.push_back('{DRAW_LINE, p - 1'b1, last_row, p, row, INK_ON, 1'b1});
    end
    last_row    = row;
    row_ring[p] = row;
    plot_col    = p + 1'b1;
    erase_col   = c + 1'b1;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    draw_cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_draws.size() == 0) begin
        $error("draw transfer with no command expected");
        errors++;
      end else begin
        want = pending_draws.pop_front();
        check_field("draw_kind", want.kind, draw_kind_o);
        check_field("x_start", want.xs, x_start_o);
        check_field("y_start", want.ys, y_start_o);
        check_field("x_end", want.xe, x_end_o);
        check_field("y_end", want.ye, y_end_o);
        check_field("ink_on", want.ink, ink_on_o);
        check_field("last_command", want.last, last_command_o);
      end
    end
  end

  // Output side: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_sample(input logic [DATA_W-1:0] sample, input logic row_known,
                             input logic [Y_W-1:0] known_row);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    absorbance_i <= sample;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    push_draw_commands(sample, row_known, known_row);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TRACE_MIN: trace_min = value;
      CFG_TRACE_MAX: trace_max = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering samples and waits for every queued command to come out.
  task automatic settle_block(input bit with_pause);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    if (with_pause) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    bit quiet;
    int lo_v;
    int hi_v;
    int swap_v;
    int a_v;
    int span_lo;
    int span_hi;

    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_TRACE_MIN;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    absorbance_i = '0;

    foreach (row_ring[i]) row_ring[i] = '0;
    plot_col  = '0;
    erase_col = COL_W'(ERASE_RESET);
    last_row  = '0;
    trace_min = TRACE_MIN_RESET;
    trace_max = TRACE_MAX_RESET;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    quiet = 1'b1;
    foreach (directed[i]) begin
      if (directed[i].is_cfg == STEP_CFG) begin
        if (!quiet) settle_block(1'b1);
        quiet = 1'b1;
        write_reg(directed[i].reg_idx, directed[i].value);
      end else begin
        quiet = 1'b0;
        send_sample(directed[i].value, directed[i].row_known, directed[i].row);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block(1'b1);
      lo_v = $signed(16'($urandom));
      hi_v = $signed(16'($urandom));
      case ($urandom_range(9))
        0: hi_v = lo_v;
        1: begin
          if (lo_v < hi_v) begin
            swap_v = lo_v;
            lo_v   = hi_v;
            hi_v   = swap_v;
          end
        end
        2: begin
          // Narrow span, only a few codes wide.
          if (lo_v > 32767 - 40) lo_v = 32767 - 40;
          hi_v = lo_v + int'($urandom_range(40, 1));
        end
        default: begin
          if (lo_v > hi_v) begin
            swap_v = lo_v;
            lo_v   = hi_v;
            hi_v   = swap_v;
          end
        end
      endcase
      if (ph == 0) begin
        lo_v = 0;
        hi_v = 8192;
      end
      write_reg(CFG_TRACE_MIN, 16'(lo_v));
      write_reg(CFG_TRACE_MAX, 16'(hi_v));

      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 16; sink_stall_pct = 16; end
      endcase
      // Hold the output long enough that the block backs up into its input.
      if (ph == 2) hold_off_req = HOLD_CYCLES;

      span_lo = (lo_v < hi_v) ? lo_v : hi_v;
      span_hi = (lo_v < hi_v) ? hi_v : lo_v;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 5 && k == PHASE_ITEMS / 2) settle_block(1'b0);
        case ($urandom_range(9))
          0, 1, 2, 3: a_v = $signed(16'($urandom));
          8: a_v = lo_v;
          9: a_v = hi_v;
          default: a_v = span_lo + int'($urandom_range(span_hi - span_lo));
        endcase
        send_sample(16'(a_v), 1'b0, '0);
      end
    end

    settle_block(1'b1);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
